### rtl/vertex_dedup_index_table_core_macros.svh
// assertion macros for the vertex dedup index table core
// no dependencies; included by the files that carry concurrent checks
`ifndef VERTEX_DEDUP_INDEX_TABLE_CORE_MACROS_SVH
`define VERTEX_DEDUP_INDEX_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define VDIT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define VDIT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VDIT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define VDIT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/vdit_pkg.sv
// shared types and sizing constants for the vertex dedup index table
// no dependencies
`default_nettype none

package vdit_pkg;

    localparam int TABLE_DEPTH = 1024;
    // compare cells in the chain, power of two
    localparam int CELL_COUNT  = 8;
    localparam int ROW_COUNT   = (TABLE_DEPTH + CELL_COUNT - 1) / CELL_COUNT;
    localparam int CELL_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int ROW_W       = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int ENTRY_W     = ROW_W + CELL_W;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int COORD_W     = 32;
    localparam int VERTEX_W    = 3 * COORD_W;
    localparam int INDEX_W     = 10;
    localparam int COUNT_W     = 11;

    typedef logic [VERTEX_W-1:0] vdit_vertex_t;

    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_z;
    } vdit_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] vertex_index;
        logic               was_new;
        logic               overflow;
        logic [COUNT_W-1:0] unique_count;
    } vdit_result_t;

    // hit token passed down the cell chain
    typedef struct packed {
        logic              hit;
        logic [CELL_W-1:0] lane;
    } vdit_link_t;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

endpackage

`default_nettype wire

### rtl/vertex_dedup_index_table_core.sv
// top level: scan sequencer, entry counter and the chain of compare cells
// depends on vdit_pkg, vdit_cell and vertex_dedup_index_table_core_macros.svh
//
//   port group        | role                        | handshake
//   ------------------+-----------------------------+---------------------------------
//   start/busy/item   | corner vertex or clear      | taken when start && !busy
//   done/result       | index, flags, unique count  | one-cycle strobe, no backpressure
//
// clear, and the first vertex into an empty table, complete without leaving idle and keep busy low.
// otherwise the eight cells scan one row of the table per cycle through their bank
// read ports: a hit ends the scan at the row that holds it, a miss once the last
// live row is checked, and a miss stores the new vertex, or flags overflow when full.
// reset empties the table at once; bank contents are never cleared.
// results cannot be stalled; a new transaction may be started while done is shown.
`default_nettype none
`include "vertex_dedup_index_table_core_macros.svh"

module vertex_dedup_index_table_core
    import vdit_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   start,
    output logic        busy,
    input  wire vdit_item_t item,
    output logic        done,
    output vdit_result_t result
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } vdit_state_t;

    vdit_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    vdit_vertex_t       key_reg, key_next;
    logic               issue_on_reg, issue_on_next;
    logic [ROW_W-1:0]   issue_row_reg, issue_row_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [ROW_W-1:0]   chk_row_reg, chk_row_next;
    logic               chk_last_reg, chk_last_next;
    logic               done_reg, done_next;
    vdit_result_t       result_reg, result_next;

    logic               accept;
    logic               wr_en;
    vdit_vertex_t       wr_vertex;
    logic [ENTRY_W-1:0] wr_pos;
    logic [ENTRY_W-1:0] last_pos;
    logic [ROW_W-1:0]   last_row;
    logic [ENTRY_W-1:0] hit_pos;
    logic               table_full;
    logic [CELL_COUNT-1:0] lane_ok;
    vdit_link_t         link [CELL_COUNT+1];

    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign done       = done_reg;
    assign result     = result_reg;
    assign wr_pos     = ENTRY_W'(count_reg);
    assign last_pos   = ENTRY_W'(count_reg - CNT_W'(1));
    assign last_row   = last_pos[ENTRY_W-1:CELL_W];
    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));
    assign hit_pos    = {chk_row_reg, link[CELL_COUNT].lane};
    assign link[0]    = '0;

    genvar c;
    generate
        for (c = 0; c < CELL_COUNT; c++)
        begin : g_cell
            // only entries below the count are live
            assign lane_ok[c] = ({chk_row_reg, CELL_W'(c)} < count_reg);

            vdit_cell u_cell (
                .clk       (clk),
                .lane      (CELL_W'(c)),
                .rd_en     (issue_on_reg),
                .rd_row    (issue_row_reg),
                .wr_en     (wr_en),
                .wr_row    (wr_pos[ENTRY_W-1:CELL_W]),
                .wr_lane   (wr_pos[CELL_W-1:0]),
                .wr_vertex (wr_vertex),
                .key       (key_reg),
                .lane_ok   (lane_ok[c]),
                .link_in   (link[c]),
                .link_out  (link[c+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        key_next       = key_reg;
        issue_on_next  = issue_on_reg;
        issue_row_next = issue_row_reg;
        chk_valid_next = chk_valid_reg;
        chk_row_next   = chk_row_reg;
        chk_last_next  = chk_last_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        wr_en          = 1'b0;
        wr_vertex      = key_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.cmd == CMD_CLEAR)
                    begin
                        count_next  = '0;
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                    else if (count_reg == '0)
                    begin
                        // empty table: store straight away at entry zero
                        wr_en                    = 1'b1;
                        wr_vertex                = {item.coord_x, item.coord_y, item.coord_z};
                        count_next               = CNT_W'(1);
                        done_next                = 1'b1;
                        result_next.vertex_index = '0;
                        result_next.was_new      = 1'b1;
                        result_next.overflow     = 1'b0;
                        result_next.unique_count = COUNT_W'(1);
                    end
                    else
                    begin
                        key_next       = {item.coord_x, item.coord_y, item.coord_z};
                        issue_on_next  = 1'b1;
                        issue_row_next = '0;
                        chk_valid_next = 1'b0;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                chk_valid_next = issue_on_reg;
                chk_row_next   = issue_row_reg;
                chk_last_next  = (issue_row_reg == last_row);
                if (issue_on_reg)
                begin
                    issue_on_next  = (issue_row_reg != last_row);
                    issue_row_next = ROW_W'(issue_row_reg + 1'b1);
                end

                if (chk_valid_reg && link[CELL_COUNT].hit)
                begin
                    done_next                = 1'b1;
                    result_next.vertex_index = INDEX_W'(hit_pos);
                    result_next.was_new      = 1'b0;
                    result_next.overflow     = 1'b0;
                    result_next.unique_count = COUNT_W'(count_reg);
                    issue_on_next            = 1'b0;
                    chk_valid_next           = 1'b0;
                    state_next               = ST_IDLE;
                end
                else if (chk_valid_reg && chk_last_reg)
                begin
                    done_next      = 1'b1;
                    issue_on_next  = 1'b0;
                    chk_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                    if (table_full)
                    begin
                        result_next.vertex_index = '0;
                        result_next.was_new      = 1'b0;
                        result_next.overflow     = 1'b1;
                        result_next.unique_count = COUNT_W'(count_reg);
                    end
                    else
                    begin
                        wr_en                    = 1'b1;
                        count_next               = CNT_W'(count_reg + 1'b1);
                        result_next.vertex_index = INDEX_W'(wr_pos);
                        result_next.was_new      = 1'b1;
                        result_next.overflow     = 1'b0;
                        result_next.unique_count = COUNT_W'(count_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                state_next     = ST_IDLE;
                issue_on_next  = 1'b0;
                chk_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_on_reg  <= 1'b0;
            chk_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_on_reg  <= issue_on_next;
            chk_valid_reg <= chk_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        issue_row_reg <= issue_row_next;
        chk_row_reg   <= chk_row_next;
        chk_last_reg  <= chk_last_next;
        result_reg    <= result_next;
    end

    `VDIT_ASSERT_IMPL(a_count_in_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH), "entry count beyond table depth")
    `VDIT_ASSERT_IMPL(a_flags_exclusive, clk, rst_n, done_reg, !(result_reg.was_new && result_reg.overflow), "new and overflow flagged together")
    `VDIT_ASSERT_IMPL(a_new_bumps_count, clk, rst_n, done_reg && result_reg.was_new, count_reg == CNT_W'($past(count_reg) + 1'b1), "insert did not advance the count")
    `VDIT_ASSERT_IMPL(a_check_only_in_scan, clk, rst_n, chk_valid_reg || issue_on_reg, state_reg == ST_SCAN, "row pipeline active outside a scan")
    `VDIT_ASSERT_NEXT(a_overflow_needs_full, clk, rst_n, state_reg == ST_SCAN && !table_full, !(done_reg && result_reg.overflow), "overflow reported with room left")

endmodule

`default_nettype wire

### rtl/vdit_cell.sv
// one compare cell: a bank of stored vertices, a registered read and an exact match
// depends on vdit_pkg
`default_nettype none

module vdit_cell
    import vdit_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [CELL_W-1:0] lane,
    input  wire logic              rd_en,
    input  wire logic [ROW_W-1:0]  rd_row,
    input  wire logic              wr_en,
    input  wire logic [ROW_W-1:0]  wr_row,
    input  wire logic [CELL_W-1:0] wr_lane,
    input  wire vdit_vertex_t      wr_vertex,
    input  wire vdit_vertex_t      key,
    input  wire logic              lane_ok,
    input  wire vdit_link_t        link_in,
    output vdit_link_t             link_out
);

    vdit_vertex_t bank_mem [ROW_COUNT];
    vdit_vertex_t rd_data_reg;
    logic         match;

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_lane == lane))
        begin
            bank_mem[wr_row] <= wr_vertex;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= bank_mem[rd_row];
        end
    end

    assign match = lane_ok && (rd_data_reg == key);

    // an earlier lane keeps priority
    always_comb
    begin
        link_out = link_in;
        if (!link_in.hit && match)
        begin
            link_out.hit  = 1'b1;
            link_out.lane = lane;
        end
    end

endmodule

`default_nettype wire

### tb/sv/vertex_dedup_index_table_core_test.sv
// self-checking testbench for vertex_dedup_index_table_core: exact-match vertex welding
// depends on vdit_pkg and the core rtl; predicts every result and compares it in order
// directed corners, a fill to full depth with overflow probes, then a random corner stream
module vertex_dedup_index_table_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import vdit_pkg::*;

    localparam int RANDOM_ITEMS  = 150;
    localparam int CALM_TAIL     = 40;
    localparam int SETTLE_CYCLES = ROW_COUNT + 16;
    localparam int REPORT_LIMIT  = 10;

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    vdit_item_t   item;
    logic         done;
    vdit_result_t result;

    // predicted table contents and fill level
    vdit_vertex_t welded_verts [TABLE_DEPTH];
    int unsigned  weld_count;
    vdit_result_t pending_welds [$];

    int unsigned  items_sent;
    int unsigned  results_seen;
    int unsigned  mismatch_count;
    int unsigned  clears_seen;
    int unsigned  new_seen;
    int unsigned  hits_seen;
    int unsigned  overflows_seen;
    int unsigned  peak_count;

    vertex_dedup_index_table_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("vertex_dedup_index_table_core_test NOT OK");
        $finish;
    end

    function automatic vdit_result_t weld_vertex(input vdit_item_t it);
        vdit_result_t r;
        vdit_vertex_t v;
        bit           hit;
        r   = '0;
        hit = 1'b0;
        v   = {it.coord_x, it.coord_y, it.coord_z};
        if (it.cmd == CMD_CLEAR)
        begin
            weld_count = 0;
            clears_seen++;
        end
        else
        begin
            for (int j = 0; j < weld_count; j++)
            begin
                if (welded_verts[j] == v)
                begin
                    r.vertex_index = j[INDEX_W-1:0];
                    hit = 1'b1;
                    break;
                end
            end
            if (hit)
                hits_seen++;
            else if (weld_count < TABLE_DEPTH)
            begin
                r.vertex_index = weld_count[INDEX_W-1:0];
                welded_verts[weld_count] = v;
                weld_count++;
                r.was_new = 1'b1;
                new_seen++;
            end
            else
            begin
                r.overflow = 1'b1;
                overflows_seen++;
            end
        end
        if (weld_count > peak_count)
            peak_count = weld_count;
        r.unique_count = weld_count[COUNT_W-1:0];
        return r;
    endfunction

    task automatic report_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic check_weld_result(input vdit_result_t got);
        vdit_result_t want;
        if (pending_welds.size() == 0)
        begin
            report_failure($sformatf("unexpected result idx %0d new %0b ovf %0b count %0d",
                got.vertex_index, got.was_new, got.overflow, got.unique_count));
            return;
        end
        want = pending_welds.pop_front();
        results_seen++;
        if (got.vertex_index !== want.vertex_index || got.was_new !== want.was_new ||
            got.overflow !== want.overflow || got.unique_count !== want.unique_count)
            report_failure($sformatf(
                "#%0d exp idx %0d new %0b ovf %0b cnt %0d got idx %0d new %0b ovf %0b cnt %0d",
                results_seen, want.vertex_index, want.was_new, want.overflow, want.unique_count,
                got.vertex_index, got.was_new, got.overflow, got.unique_count));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
            check_weld_result(result);
    end

    // called at a falling edge; returns at the falling edge after acceptance, start still high
    task automatic send_item(input vdit_item_t it);
        vdit_result_t expected;
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        expected = weld_vertex(it);
        pending_welds = {pending_welds, expected};
        items_sent++;
        @(negedge clk);
    endtask

    task automatic idle_for(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic maybe_idle();
        if ($urandom_range(0, 3) == 0)
            idle_for($urandom_range(1, 7));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_welds.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic vdit_item_t lookup_item(input vdit_vertex_t v);
        vdit_item_t it;
        it.cmd = CMD_LOOKUP;
        {it.coord_x, it.coord_y, it.coord_z} = v;
        return it;
    endfunction

    function automatic vdit_item_t clear_item();
        vdit_item_t it;
        it.cmd     = CMD_CLEAR;
        it.coord_x = $urandom();
        it.coord_y = $urandom();
        it.coord_z = $urandom();
        return it;
    endfunction

    function automatic vdit_vertex_t random_vertex();
        return {$urandom(), $urandom(), $urandom()};
    endfunction

    // zeros of both signs, infinities, nans and one ordinary value (1.0)
    function automatic logic [COORD_W-1:0] special_coord();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'h7fc0_0000;
            3: return 32'hffc0_0000;
            4: return 32'h7f80_0000;
            5: return 32'hff80_0000;
            6: return 32'h7f80_0001;
            default: return 32'h3f80_0000;
        endcase
    endfunction

    function automatic vdit_vertex_t flip_one_bit(input vdit_vertex_t v);
        int unsigned b;
        b = $urandom_range(0, VERTEX_W - 1);
        v[b] = ~v[b];
        return v;
    endfunction

    task automatic test_directed_corners();
        send_item(clear_item());
        send_item(lookup_item({32'h0000_0000, 32'h0000_0000, 32'h0000_0000}));
        send_item(lookup_item({32'h0000_0000, 32'h0000_0000, 32'h0000_0000}));
        // negative zero in each coordinate is a separate vertex
        send_item(lookup_item({32'h8000_0000, 32'h0000_0000, 32'h0000_0000}));
        send_item(lookup_item({32'h0000_0000, 32'h8000_0000, 32'h0000_0000}));
        send_item(lookup_item({32'h0000_0000, 32'h0000_0000, 32'h8000_0000}));
        send_item(lookup_item({3{32'hffff_ffff}}));
        send_item(lookup_item({3{32'h7fc0_0000}}));
        send_item(lookup_item({3{32'h7fc0_0000}}));
        send_item(lookup_item({32'h7fc0_0000, 32'h7fc0_0000, 32'h7fc0_0001}));
        send_item(lookup_item({3{32'hffff_ffff}}));
        send_item(lookup_item({32'h8000_0000, 32'h0000_0000, 32'h0000_0000}));
        send_item(lookup_item({32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa}));
        send_item(lookup_item({32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555}));
        send_item(lookup_item({32'h0000_0001, 32'h0000_0000, 32'h0000_0000}));
        send_item(lookup_item({32'h0000_0000, 32'h0000_0000, 32'h0000_0000}));
        send_item(clear_item());
        send_item(clear_item());
        send_item(lookup_item({3{32'hffff_ffff}}));
        send_item(lookup_item({3{32'hffff_ffff}}));
        drain_results();
    endtask

    task automatic test_fill_and_overflow();
        vdit_vertex_t v;
        send_item(clear_item());
        while (weld_count < TABLE_DEPTH)
        begin
            send_item(lookup_item(random_vertex()));
            if ($urandom_range(0, 15) == 0)
                maybe_idle();
        end
        // misses against a full table store nothing
        send_item(lookup_item(random_vertex()));
        send_item(lookup_item(flip_one_bit(welded_verts[TABLE_DEPTH-1])));
        drain_results();
        send_item(lookup_item(random_vertex()));
        send_item(lookup_item(welded_verts[0]));
        send_item(lookup_item(welded_verts[TABLE_DEPTH-1]));
        repeat (6)
        begin
            send_item(lookup_item(welded_verts[$urandom_range(0, TABLE_DEPTH - 1)]));
            maybe_idle();
        end
        v = welded_verts[TABLE_DEPTH/2];
        send_item(clear_item());
        send_item(lookup_item(v));
        drain_results();
    endtask

    task automatic test_random_stream();
        vdit_item_t  it;
        int unsigned pick;
        send_item(clear_item());
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 1)
                it = clear_item();
            else if (pick < 45 && weld_count > 0)
                it = lookup_item(welded_verts[$urandom_range(0, weld_count - 1)]);
            else if (pick < 60 && weld_count > 0)
                it = lookup_item(flip_one_bit(welded_verts[$urandom_range(0, weld_count - 1)]));
            else if (pick < 72)
                it = lookup_item({special_coord(), special_coord(), special_coord()});
            else
                it = lookup_item(random_vertex());
            send_item(it);
            if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3)
                drain_results();
            else if (n < RANDOM_ITEMS - CALM_TAIL)
                maybe_idle();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        weld_count = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_corners();
        test_fill_and_overflow();
        test_random_stream();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d transactions: %0d clears, %0d new vertices, %0d hits, %0d overflows",
            items_sent, clears_seen, new_seen, hits_seen, overflows_seen);
        $display("table peaked at %0d vertices; %0d results checked, %0d failures",
            peak_count, results_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("vertex_dedup_index_table_core_test OK");
        else
            $display("vertex_dedup_index_table_core_test NOT OK");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/vdit_pkg.sv
rtl/vdit_cell.sv
rtl/vertex_dedup_index_table_core.sv
tb/sv/vertex_dedup_index_table_core_test.sv
